[rtl/gcpe_pkg.sv]
`timescale 1ns / 1ps
// Package for the glyph cell pixel expander: sizes, codes, command/status types.
// No dependencies; imported by the interfaces and every module of the block.
package gcpe_pkg;

    // Font and frame geometry
    localparam int GLYPH_COUNT     = 256;
    localparam int MAX_LINE_PIXELS = 1024;
    localparam int STORE_DEPTH     = GLYPH_COUNT * 8;
    localparam int GLYPH_W         = $clog2(GLYPH_COUNT);
    localparam int FONT_AW         = GLYPH_W + 3;
    localparam int PITCH_W         = $clog2(MAX_LINE_PIXELS + 1);

    // Field widths
    localparam int CELL_W    = 16;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 6;
    localparam int FIDX_W    = 11;
    localparam int FBITS_W   = 8;
    localparam int ADDR_W    = 19;
    localparam int QUAD_W    = 64;
    localparam int COLOR_W   = 16;
    localparam int LINE_W    = 11;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 64;
    localparam int RESULTS_W = 4;

    // Reset value of the line pitch register
    localparam logic [LINE_W-1:0] LINE_PIXELS_RST = LINE_W'(320);

    // Item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_PAL_0_3   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_PAL_4_7   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_PAL_8_11  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_PAL_12_15 = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_LINE_PIX  = 3'd4;

    // Glyph code folded into the font: code modulo glyph count, built at elaboration
    typedef logic [GLYPH_W-1:0] glyph_map_t [256];

    function automatic glyph_map_t make_glyph_map();
        glyph_map_t m;
        for (int i = 0; i < 256; i++) begin
            m[i] = GLYPH_W'(i % GLYPH_COUNT);
        end
        return m;
    endfunction

    localparam glyph_map_t GLYPH_MAP = make_glyph_map();

    // Controller to datapath commands
    typedef struct packed {
        logic       font_wr;   // load transaction accepted
        logic       capture;   // draw transaction accepted
        logic       setup;     // compute first line address
        logic       emit;      // load one result into the output register
        logic       half;      // right half of the glyph row
        logic       last;      // sixteenth result of the cell
        logic [2:0] rd_row;    // glyph row the font read fetches this cycle
    } gcpe_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;        // output register can take a result
    } gcpe_stat_t;

endpackage

[rtl/gcpe_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: item input, result output and configuration write.
// Depends on gcpe_pkg for field widths.

interface gcpe_in_if import gcpe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [CELL_W-1:0]    cell_word;
    logic [COL_W-1:0]     cell_col;
    logic [ROW_W-1:0]     cell_row;
    logic [FIDX_W-1:0]    font_index;
    logic [FBITS_W-1:0]   font_bits;

    modport source (output valid, cmd, cell_word, cell_col, cell_row, font_index, font_bits,
                    input ready);
    modport sink   (input valid, cmd, cell_word, cell_col, cell_row, font_index, font_bits,
                    output ready);
endinterface

interface gcpe_out_if import gcpe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    pixel_addr;
    logic [QUAD_W-1:0]    pixel_quad;
    logic                 last;

    modport source (output valid, pixel_addr, pixel_quad, last, input ready);
    modport sink   (input valid, pixel_addr, pixel_quad, last, output ready);
endinterface

interface gcpe_cfg_if import gcpe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_AW-1:0]    addr;
    logic [CFG_DW-1:0]    data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/glyph_cell_pixel_expander_top.sv]
`timescale 1ns / 1ps
// Top level of the 8x8 text-mode glyph cell pixel expander.
// Depends on gcpe_pkg, gcpe_if, gcpe_ctrl and gcpe_datapath.
//
//  Channel  Dir  Payload                                            Per transaction
//  item     in   cmd, cell_word, cell_col, cell_row, font_index,    one font byte load
//                font_bits                                          or one cell draw
//  result   out  pixel_addr, pixel_quad, last                       four pixels
//  cfg      in   addr, data                                         one register write
//
// A font load produces no result.
// A draw first passes a setup state that multiplies the row by the pitch, then loads one
// result per cycle from the font memory read port while the result side is ready.
// item.ready is low from a draw's acceptance until its sixteenth result is loaded into the
// output register; result stalls hold the sequence in place.
// Reset clears control state, the palette (to zero) and the pitch (to 320).
module glyph_cell_pixel_expander_top import gcpe_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    gcpe_in_if.sink    item,
    gcpe_out_if.source result,
    gcpe_cfg_if.sink   cfg
);

    gcpe_cmd_t  cmd;
    gcpe_stat_t stat;
    logic       item_ready;
    logic       cfg_ready;

    gcpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_cmd   (item.cmd),
        .in_ready (item_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gcpe_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_word  (item.cell_word),
        .cell_col   (item.cell_col),
        .cell_row   (item.cell_row),
        .font_index (item.font_index),
        .font_bits  (item.font_bits),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg.addr),
        .cfg_data   (cfg.data),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_addr   (result.pixel_addr),
        .out_quad   (result.pixel_quad),
        .out_last   (result.last),
        .cmd        (cmd),
        .stat       (stat)
    );

    assign item.ready = item_ready;
    assign cfg.ready  = cfg_ready;

endmodule

[rtl/gcpe_ctrl.sv]
`timescale 1ns / 1ps
// Controller: accepts items and sequences the sixteen results of a draw.
// Depends on gcpe_pkg for command and status types.
module gcpe_ctrl import gcpe_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_cmd,
    output logic       in_ready,
    input  gcpe_stat_t stat,
    output gcpe_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [RESULTS_W-1:0] cnt_reg, cnt_next;
    logic                 accept;
    logic                 emit;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign emit     = (state_reg == ST_EMIT) && stat.out_free;

    // Next state and result counter
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_cmd == CMD_DRAW))
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cnt_next = cnt_reg;
                if (emit)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == '1)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Commands to the datapath
    always_comb
    begin
        cmd.font_wr = accept && (in_cmd == CMD_LOAD);
        cmd.capture = accept && (in_cmd == CMD_DRAW);
        cmd.setup   = (state_reg == ST_SETUP);
        cmd.emit    = emit;
        cmd.half    = cnt_reg[0];
        cmd.last    = (cnt_reg == '1);
        cmd.rd_row  = cnt_next[RESULTS_W-1:1];
    end

endmodule

[rtl/gcpe_datapath.sv]
`timescale 1ns / 1ps
// Datapath: config registers, font memory, address arithmetic, output register.
// Depends on gcpe_pkg; driven by gcpe_ctrl commands.
module gcpe_datapath import gcpe_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    // item payload
    input  logic [CELL_W-1:0]   cell_word,
    input  logic [COL_W-1:0]    cell_col,
    input  logic [ROW_W-1:0]    cell_row,
    input  logic [FIDX_W-1:0]   font_index,
    input  logic [FBITS_W-1:0]  font_bits,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_data,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ADDR_W-1:0]   out_addr,
    output logic [QUAD_W-1:0]   out_quad,
    output logic                out_last,
    // control
    input  gcpe_cmd_t           cmd,
    output gcpe_stat_t          stat
);

    localparam int MUL_W = ROW_W + 3 + PITCH_W;
    localparam int SUM_W = (MUL_W + 1 > ADDR_W) ? MUL_W + 1 : ADDR_W;
    localparam int CMP_W = (PITCH_W > LINE_W) ? PITCH_W : LINE_W;

    logic [CFG_DW-1:0]   palette_reg [4];
    logic [LINE_W-1:0]   line_pixels_reg;
    logic                cfg_we;

    logic [7:0]          font_mem [STORE_DEPTH];
    logic [FBITS_W-1:0]  font_q_reg;
    logic                font_we;
    logic [FONT_AW-1:0]  font_waddr;
    logic [FONT_AW-1:0]  font_raddr;

    logic [GLYPH_W-1:0]  glyph_reg;
    logic [COLOR_W-1:0]  bg_reg, fg_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [PITCH_W-1:0]  pitch_reg, pitch_next;
    logic [ADDR_W-1:0]   line_addr_reg;
    logic [MUL_W-1:0]    row_prod;
    logic [SUM_W-1:0]    first_sum;
    logic [CMP_W-1:0]    line_ext;

    logic                out_valid_reg;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [QUAD_W-1:0]   out_quad_reg, out_quad_next;
    logic                out_last_reg;
    logic [3:0]          nibble;

    function automatic logic [COLOR_W-1:0] colour_of(input logic [3:0] idx,
                                                     input logic [CFG_DW-1:0] pal [4]);
        logic [CFG_DW-1:0] word;
        word = pal[idx[3:2]];
        return word[{idx[1:0], 4'b0000} +: COLOR_W];
    endfunction

    // Configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg[0]  <= '0;
            palette_reg[1]  <= '0;
            palette_reg[2]  <= '0;
            palette_reg[3]  <= '0;
            line_pixels_reg <= LINE_PIXELS_RST;
        end
        else if (cfg_we)
        begin
            priority case (cfg_addr)
                CFG_PAL_0_3:   palette_reg[0]  <= cfg_data;
                CFG_PAL_4_7:   palette_reg[1]  <= cfg_data;
                CFG_PAL_8_11:  palette_reg[2]  <= cfg_data;
                CFG_PAL_12_15: palette_reg[3]  <= cfg_data;
                CFG_LINE_PIX:  line_pixels_reg <= cfg_data[LINE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Font memory: one write port for loads, registered read for draws
    assign font_we    = cmd.font_wr && (int'(font_index) < STORE_DEPTH);
    assign font_waddr = FONT_AW'(font_index);
    assign font_raddr = {glyph_reg, cmd.rd_row};

    always_ff @(posedge clk)
    begin
        if (font_we)
            font_mem[font_waddr] <= font_bits;
        font_q_reg <= font_mem[font_raddr];
    end

    // Cell capture on draw acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            glyph_reg <= GLYPH_MAP[cell_word[7:0]];
            bg_reg    <= colour_of(cell_word[11:8], palette_reg);
            fg_reg    <= colour_of(cell_word[15:12], palette_reg);
            col_reg   <= cell_col;
            row_reg   <= cell_row;
        end
    end

    // Pitch saturation and first line address
    assign line_ext   = CMP_W'(line_pixels_reg);
    assign pitch_next = (line_ext > CMP_W'(MAX_LINE_PIXELS)) ? PITCH_W'(MAX_LINE_PIXELS)
                                                             : PITCH_W'(line_ext);
    assign row_prod   = MUL_W'({row_reg, 3'b000}) * MUL_W'(pitch_next);
    assign first_sum  = SUM_W'(row_prod) + SUM_W'({col_reg, 3'b000});

    // Line address: set at setup, one pitch per finished glyph row
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            pitch_reg     <= pitch_next;
            line_addr_reg <= first_sum[ADDR_W-1:0];
        end
        else if (cmd.emit && cmd.half)
        begin
            line_addr_reg <= line_addr_reg + ADDR_W'(pitch_reg);
        end
    end

    // Result assembly: left half uses the upper nibble, leftmost pixel on top
    assign nibble        = cmd.half ? font_q_reg[3:0] : font_q_reg[7:4];
    assign out_addr_next = cmd.half ? line_addr_reg + ADDR_W'(4) : line_addr_reg;

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            out_quad_next[QUAD_W-1-COLOR_W*p -: COLOR_W] = nibble[3-p] ? fg_reg : bg_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_addr_reg <= out_addr_next;
            out_quad_reg <= out_quad_next;
            out_last_reg <= cmd.last;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_addr      = out_addr_reg;
    assign out_quad      = out_quad_reg;
    assign out_last      = out_last_reg;

endmodule

[rtl/gcpe_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the glyph cell pixel expander, bound to the top level.
// Depends on gcpe_pkg; sees only top-level port signals.
module gcpe_checker import gcpe_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_cmd,
    input logic out_valid,
    input logic out_ready,
    input logic out_last
);

    logic [RESULTS_W-1:0] seen_reg;
    logic                 in_acc;
    logic                 out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Count delivered results modulo sixteen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (out_acc)
            seen_reg <= seen_reg + 1'b1;
    end

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A draw blocks further items right after acceptance
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_cmd == CMD_DRAW) |=> !in_ready)
        else $error("item accepted during a draw");

    // last marks exactly every sixteenth delivered result
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (out_last == (seen_reg == '1)))
        else $error("last flag out of place");

    // Items are taken mid-cell only while the final result of that cell is still offered
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && (seen_reg != '0) |-> out_valid)
        else $error("cell sequence ended early");

endmodule

bind glyph_cell_pixel_expander_top gcpe_checker u_gcpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_cmd    (item.cmd),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_last  (result.last)
);
